@@ sv/tvps_pkg.sv @@
// ----------------------------------------------------------------------------
// tvps_pkg: shared types and constants of the three-voice pulse synthesizer
// Item formats, voice state layout, register indexes and control codes.
// ----------------------------------------------------------------------------
package tvps_pkg;

  localparam int VOICES            = 3;
  localparam int CTRL_CHANNELS     = 8;
  localparam int DEF_TABLE_DEPTH   = 512;

  localparam int SMP_W   = 10;
  localparam int PER_W   = 16;
  localparam int NUM_W   = PER_W + 3;
  localparam int DEN_W   = 13;
  localparam int CH_W    = $clog2(CTRL_CHANNELS);

  localparam logic [PER_W-1:0] START_PERIOD_RESET = 16'd1000;

  localparam logic [1:0] REG_START0 = 2'd0;
  localparam logic [1:0] REG_START1 = 2'd1;
  localparam logic [1:0] REG_START2 = 2'd2;

  localparam logic OPC_TICK  = 1'b0;
  localparam logic OPC_TABLE = 1'b1;

  localparam logic [3:0] PHASE_SAMPLE = 4'd0;
  localparam logic [3:0] PHASE_TUNE0  = 4'd4;
  localparam logic [3:0] PHASE_TUNE1  = 4'd8;
  localparam logic [3:0] PHASE_TUNE2  = 4'd12;

  localparam logic [CH_W-1:0] SMP_GLOBAL_PERIOD = 3'd6;
  localparam logic [CH_W-1:0] SMP_GLOBAL_WIDTH  = 3'd7;

  localparam logic [DEN_W-1:0] DIV_OFFSET = 13'd15;

  typedef struct packed {
    logic              opcode;
    logic [SMP_W-1:0]  adc_value;
    logic [8:0]        table_index;
    logic [PER_W-1:0]  table_value;
  } in_item_t;

  typedef struct packed {
    logic [VOICES-1:0] voice_bits;
    logic [CH_W-1:0]   next_channel;
  } out_item_t;

  typedef struct packed {
    logic [PER_W-1:0] count;
    logic [PER_W-1:0] period;
    logic [PER_W-1:0] width;
  } voice_t;

endpackage

@@ sv/tvps_div.sv @@
// ----------------------------------------------------------------------------
// tvps_div: restoring divider for the pulse width
// Produces one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module tvps_div import tvps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [PER_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[PER_W-1:0];

endmodule

@@ sv/three_voice_pulse_synth.sv @@
// ----------------------------------------------------------------------------
// three_voice_pulse_synth: bank of three pulse-wave voices
// Tick-driven voices with table-based retuning from stored control samples.
// ----------------------------------------------------------------------------
// A table write item is taken while idle and leaves the block idle. A tick item
// walks the three voice entries through the voice memory and then loads the
// result in the output step, after which the next item can be accepted.
// On the three retune phases the tick first reads four control samples, then
// forms the divisor product and reads the period table. It then divides for
// the new pulse width at one quotient bit per cycle in the 19-step divider
// before the voice pass. One tick is worked on at a time, and a result that is
// still stalled when the next one is ready holds the block until the output is
// free.
module three_voice_pulse_synth import tvps_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [PER_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o
);

  localparam int TIW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SAMP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_TBL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_VOX  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [PER_W-1:0]   start_q [VOICES];
  logic               started_q;
  logic [3:0]         phase_q;
  logic [CH_W-1:0]    ch_q;
  logic               tune_q;
  logic [1:0]         tgt_q;
  logic [2:0]         sc_q;
  logic [1:0]         vc_q;
  logic [VOICES-1:0]  bits_q;
  logic [SMP_W-1:0]   adc_q;
  logic [SMP_W-1:0]   p_q, w_q, gp_q, gw_q;
  logic [DEN_W-1:0]   prod_q;
  logic [PER_W-1:0]   per_q;
  out_item_t          res_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic [SMP_W-1:0]   smp_mem [CTRL_CHANNELS];
  logic [CTRL_CHANNELS-1:0] smp_vld_q;
  logic [SMP_W-1:0]   smp_rd_q;
  logic               smp_rv_q;
  logic [CH_W-1:0]    smp_raddr;
  logic [SMP_W-1:0]   smp_data;

  logic [PER_W-1:0]   tbl_mem [TABLE_DEPTH];
  logic [PER_W-1:0]   tbl_rd_q;
  logic [TIW-1:0]     tbl_raddr;
  logic [SMP_W:0]     idx_sum;
  logic [8:0]         idx9;
  logic               tbl_we;

  voice_t             vmem [VOICES];
  voice_t             vrd_q;
  voice_t             vwr;
  logic               v_we;
  logic [1:0]         pv;
  logic [PER_W-1:0]   base_cnt, base_per, base_pw, cnt_dec, cnt_new;
  logic               bit_now, hit, finish;
  logic [VOICES-1:0]  bits_now;

  logic [6:0]         fa, fb;
  logic               div_start, div_done;
  logic [PER_W-1:0]   quo;

  logic               in_acc, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tbl_we     = in_acc && (in_item_i.opcode == OPC_TABLE)
                      && (32'(in_item_i.table_index) < 32'(TABLE_DEPTH));

  always_comb begin
    case (sc_q[1:0])
      2'd0:    smp_raddr = {tgt_q, 1'b0};
      2'd1:    smp_raddr = {tgt_q, 1'b1};
      2'd2:    smp_raddr = SMP_GLOBAL_PERIOD;
      default: smp_raddr = SMP_GLOBAL_WIDTH;
    endcase
  end
  assign smp_data = smp_rv_q ? smp_rd_q : '0;

  assign idx_sum = {1'b0, p_q} + {1'b0, gp_q};
  assign idx9    = idx_sum[SMP_W:2];
  always_comb begin
    if (32'(idx9) >= 32'(TABLE_DEPTH)) begin
      tbl_raddr = TIW'(TABLE_DEPTH - 1);
    end else begin
      tbl_raddr = TIW'(idx9);
    end
  end

  assign fa = 7'(w_q[SMP_W-1:4]) + 7'd1;
  assign fb = 7'(gw_q[SMP_W-1:4]) + 7'd1;

  assign pv       = vc_q - 2'd1;
  assign base_cnt = started_q ? vrd_q.count  : start_q[pv];
  assign base_per = started_q ? vrd_q.period : start_q[pv];
  assign base_pw  = started_q ? vrd_q.width  : (start_q[pv] >> 1);
  assign cnt_dec  = base_cnt - 16'd1;
  assign cnt_new  = (cnt_dec == '0) ? base_per : cnt_dec;
  assign bit_now  = cnt_new < base_pw;
  assign hit      = tune_q && (tgt_q == pv);
  assign vwr      = '{count: cnt_new,
                      period: hit ? per_q : base_per,
                      width: hit ? quo : base_pw};
  assign v_we     = (state_q == S_VOX) && (vc_q != 2'd0);
  assign finish   = (state_q == S_VOX) && (vc_q == 2'd3);

  always_comb begin
    bits_now     = bits_q;
    bits_now[pv] = bit_now;
  end

  assign div_start = (state_q == S_TBL);
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  tvps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({tbl_rd_q, 3'b000}),
    .divisor_i  (DIV_OFFSET + prod_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_item_i.opcode == OPC_TICK)) begin
          if ((phase_q == PHASE_TUNE0) || (phase_q == PHASE_TUNE1)
              || (phase_q == PHASE_TUNE2)) begin
            state_d = S_SAMP;
          end else begin
            state_d = S_VOX;
          end
        end
      end
      S_SAMP: if (sc_q == 3'd4) state_d = S_MUL;
      S_MUL:  state_d = S_TBL;
      S_TBL:  state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_VOX;
      S_VOX:  if (finish) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= '{default: START_PERIOD_RESET};
      started_q   <= 1'b0;
      phase_q     <= '0;
      ch_q        <= '0;
      tune_q      <= 1'b0;
      tgt_q       <= '0;
      sc_q        <= '0;
      vc_q        <= '0;
      bits_q      <= '0;
      smp_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_START0: start_q[0] <= cfg_wdata_i;
          REG_START1: start_q[1] <= cfg_wdata_i;
          REG_START2: start_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        sc_q   <= '0;
        vc_q   <= '0;
        bits_q <= '0;
        case (phase_q)
          PHASE_TUNE0: begin tune_q <= 1'b1; tgt_q <= 2'd0; end
          PHASE_TUNE1: begin tune_q <= 1'b1; tgt_q <= 2'd1; end
          PHASE_TUNE2: begin tune_q <= 1'b1; tgt_q <= 2'd2; end
          default:     begin tune_q <= 1'b0; tgt_q <= 2'd0; end
        endcase
      end
      if (state_q == S_SAMP) begin
        sc_q <= sc_q + 3'd1;
      end
      if (state_q == S_VOX) begin
        vc_q <= vc_q + 2'd1;
        if (v_we) begin
          bits_q <= bits_now;
        end
      end
      if (finish) begin
        started_q <= 1'b1;
        phase_q   <= phase_q + 4'd1;
        if (phase_q == PHASE_SAMPLE) begin
          ch_q            <= ch_q + CH_W'(1);
          smp_vld_q[ch_q] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      adc_q <= in_item_i.adc_value;
    end
    if (state_q == S_SAMP) begin
      case (sc_q)
        3'd1:    p_q  <= smp_data;
        3'd2:    w_q  <= smp_data;
        3'd3:    gp_q <= smp_data;
        3'd4:    gw_q <= smp_data;
        default: ;
      endcase
    end
    if (state_q == S_MUL) begin
      prod_q <= 13'(fa) * 13'(fb);
    end
    if (state_q == S_TBL) begin
      per_q <= tbl_rd_q;
    end
    if (finish) begin
      res_q.voice_bits   <= bits_now;
      res_q.next_channel <= (phase_q == PHASE_SAMPLE) ? ch_q + CH_W'(1) : ch_q;
    end
    if (out_load) begin
      out_item_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_rd_q <= smp_mem[smp_raddr];
    smp_rv_q <= smp_vld_q[smp_raddr];
    if (finish && (phase_q == PHASE_SAMPLE)) begin
      smp_mem[ch_q] <= adc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_rd_q <= tbl_mem[tbl_raddr];
    if (tbl_we) begin
      tbl_mem[TIW'(in_item_i.table_index)] <= in_item_i.table_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vc_q != 2'd3) begin
      vrd_q <= vmem[vc_q];
    end
    if (v_we) begin
      vmem[pv] <= vwr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_result_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> started_q)
    else $error("result shown before any tick completed");

  a_samples_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_vld_q != '0) |-> started_q)
    else $error("control sample stored before any tick completed");

  a_finish_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (state_q == S_OUT))
    else $error("voice pass did not hand over to the output step");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of the three-voice pulse synthesizer
// Drives table writes and sample ticks over the valid/stall input channel.
// An in-bench voice bank predicts the voice levels and next channel of every
// tick. Results are compared field by field in order, under sender and
// receiver idling, while lookups stay on period table entries already written.
// ----------------------------------------------------------------------------
module tb;
  import tvps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam int SAMPLE_STEP  = 16;
  localparam int INDEX_DIV    = 4;
  localparam int PW_SCALE     = 8;
  localparam int ITEMS        = 800;
  localparam int SETTLE_WAIT  = 40;
  localparam int QUIET_LIMIT  = 5000;

  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum int {ADC_RANDOM, ADC_TOP, ADC_BOTTOM, ADC_LOW} adc_mode_e;

  class voice_bank_model;
    logic [PER_W-1:0] start_per [VOICES];
    logic [PER_W-1:0] count     [VOICES];
    logic [PER_W-1:0] period    [VOICES];
    logic [PER_W-1:0] width     [VOICES];
    logic [SMP_W-1:0] samples   [CTRL_CHANNELS];
    logic [CH_W-1:0]  chan;
    logic [3:0]       phase;
    bit               started;
    logic [PER_W-1:0] periods   [TABLE_DEPTH];
    bit               written   [TABLE_DEPTH];
    out_item_t        expected_levels [$];
    int               errors;

    function new();
      for (int v = 0; v < VOICES; v++) begin
        start_per[v] = START_PERIOD_RESET;
        count[v]     = '0;
        period[v]    = '0;
        width[v]     = '0;
      end
      for (int c = 0; c < CTRL_CHANNELS; c++) samples[c] = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        periods[i] = '0;
        written[i] = 1'b0;
      end
      chan    = '0;
      phase   = '0;
      started = 1'b0;
      errors  = 0;
    endfunction

    function void set_start(logic [1:0] idx, logic [PER_W-1:0] val);
      case (idx)
        REG_START0: start_per[0] = val;
        REG_START1: start_per[1] = val;
        REG_START2: start_per[2] = val;
        default: ;
      endcase
    endfunction

    function int lookup_index(int v);
      int idx;
      idx = (int'(samples[2*v]) + int'(samples[SMP_GLOBAL_PERIOD])) / INDEX_DIV;
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      return idx;
    endfunction

    function int tune_voice();
      case (phase)
        PHASE_TUNE0: return 0;
        PHASE_TUNE1: return 1;
        PHASE_TUNE2: return 2;
        default:     return -1;
      endcase
    endfunction

    // True when the next tick would retune from a table entry not yet written.
    function bit missing_entry(output int idx);
      int v;
      v   = tune_voice();
      idx = 0;
      if (v < 0) return 1'b0;
      idx = lookup_index(v);
      return !written[idx];
    endfunction

    function void retune(int v);
      int          idx;
      int unsigned per;
      int unsigned w;
      int unsigned gw;
      int unsigned dv;
      idx = lookup_index(v);
      per = periods[idx];
      w   = samples[2*v+1];
      gw  = samples[SMP_GLOBAL_WIDTH];
      dv  = DIV_OFFSET + (1 + w / SAMPLE_STEP) * (1 + gw / SAMPLE_STEP);
      period[v] = PER_W'(per);
      width[v]  = PER_W'((per * PW_SCALE) / dv);
    endfunction

    function void apply_item(in_item_t it);
      out_item_t         levels;
      logic [VOICES-1:0] bits;
      if (it.opcode == OPC_TABLE) begin
        if (int'(it.table_index) < TABLE_DEPTH) begin
          periods[it.table_index] = it.table_value;
          written[it.table_index] = 1'b1;
        end
        return;
      end
      if (!started) begin
        for (int v = 0; v < VOICES; v++) begin
          period[v] = start_per[v];
          width[v]  = start_per[v] >> 1;
          count[v]  = start_per[v];
        end
        started = 1'b1;
      end
      bits = '0;
      for (int v = 0; v < VOICES; v++) begin
        count[v] = count[v] - 1'b1;
        if (count[v] == '0) count[v] = period[v];
        bits[v] = (count[v] < width[v]);
      end
      case (phase)
        PHASE_TUNE0: retune(0);
        PHASE_TUNE1: retune(1);
        PHASE_TUNE2: retune(2);
        PHASE_SAMPLE: begin
          samples[chan] = it.adc_value;
          chan = chan + 1'b1;
        end
        default: ;
      endcase
      phase = phase + 1'b1;
      levels.voice_bits   = bits;
      levels.next_channel = chan;
      expected_levels.push_back(levels);
    endfunction

    function void compare_output(out_item_t got);
      out_item_t want;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_levels.pop_front();
      if (got.voice_bits !== want.voice_bits) begin
        $display("%0t: voice_bits mismatch, expected %b, actual %b",
                 $time, want.voice_bits, got.voice_bits);
        errors++;
      end
      if (got.next_channel !== want.next_channel) begin
        $display("%0t: next_channel mismatch, expected %0d, actual %0d",
                 $time, want.next_channel, got.next_channel);
        errors++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_index_i;
  logic [PER_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_item_o;

  voice_bank_model bank = new();

  int        tx_idle_pct;
  int        rx_stall_pct;
  int        quiet;
  adc_mode_e adc_mode;

  three_voice_pulse_synth #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #2ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) bank.compare_output(out_item_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [PER_W-1:0] rand_period();
    int unsigned r;
    r = $urandom_range(9);
    if (r <= 5) return PER_W'($urandom_range(48, 1));
    if (r == 6) return '0;
    if (r == 7) return '1;
    return PER_W'($urandom_range(65535));
  endfunction

  function automatic logic [SMP_W-1:0] rand_adc();
    case (adc_mode)
      ADC_TOP:    return '1;
      ADC_BOTTOM: return '0;
      ADC_LOW:    return SMP_W'($urandom_range(63));
      default:    return SMP_W'($urandom_range(1023));
    endcase
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the item.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    bank.apply_item(it);
  endtask

  task automatic send_table(int idx, logic [PER_W-1:0] val);
    in_item_t it;
    it.opcode      = OPC_TABLE;
    it.adc_value   = SMP_W'($urandom);
    it.table_index = 9'(idx);
    it.table_value = val;
    send_item(it);
  endtask

  task automatic send_tick(logic [SMP_W-1:0] adc);
    in_item_t it;
    int       idx;
    if (bank.missing_entry(idx)) send_table(idx, rand_period());
    it.opcode      = OPC_TICK;
    it.adc_value   = adc;
    it.table_index = 9'($urandom);
    it.table_value = PER_W'($urandom);
    send_item(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PER_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    bank.set_start(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains all expected items, then lets a possible table write finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (bank.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  initial begin
    int tx_pct [3];
    int rx_pct [3];
    int n;
    tx_pct = '{22, 70, 0};
    rx_pct = '{70, 22, 0};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;
    quiet        = 0;
    tx_idle_pct  = tx_pct[0];
    rx_stall_pct = rx_pct[0];
    adc_mode     = ADC_RANDOM;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_START0, 16'd1);
    write_reg(REG_START1, 16'hFFFF);
    write_reg(REG_START2, 16'd2);
    write_reg(REG_NONE, PER_W'($urandom));

    send_table(0, '0);
    send_table(TABLE_DEPTH - 1, '1);
    send_table(1, 16'd5);
    for (int i = 0; i < 19; i++) send_tick(i[0] ? SMP_W'('1) : SMP_W'('0));

    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = tx_pct[ph];
      rx_stall_pct = rx_pct[ph];
      for (int k = 0; k < ITEMS / 3; k++) begin
        if (n % 128 == 0) adc_mode = adc_mode_e'($urandom_range(3));
        n++;
        if ($urandom_range(99) < 10) send_table($urandom_range(TABLE_DEPTH - 1), rand_period());
        else send_tick(rand_adc());
      end
      settle();
      if (ph < 2) begin
        write_reg(REG_START0, rand_period() | 16'd1);
        write_reg(REG_START1, PER_W'($urandom_range(65535, 1)));
        write_reg(REG_START2, ph[0] ? 16'hFFFF : 16'd1);
        write_reg(REG_NONE, PER_W'($urandom));
      end
    end

    if (bank.errors == 0 && bank.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
